### sv/dfgt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// dfgt_pkg
// Types and constants shared by the depth-first traversal controller,
// datapath and top level.
// -----------------------------------------------------------------------------
package dfgt_pkg;

   localparam int VERTEX_W     = 5;
   localparam int CFG_W        = 6;
   localparam int CFG_DATA_W   = 8;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 8;
   localparam int ACTIVE_W     = 7;
   localparam logic [CFG_W-1:0] VCOUNT_RESET = 6'd32;

   typedef enum logic [1:0] {
      ACT_ADD   = 2'd0,
      ACT_RUN   = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      KIND_VISIT   = 2'd0,
      KIND_STORED  = 2'd1,
      KIND_REJECT  = 2'd2,
      KIND_CLEARED = 2'd3
   } kind_type;

   typedef struct packed {
      logic     take_item;
      logic     clear_graph;
      logic     head_rd_from;
      logic     add_edge;
      logic     run_init;
      logic     root_next;
      logic     cand_root;
      logic     cand_target;
      logic     enter;
      logic     push;
      logic     pop;
      logic     pop_load;
      logic     edge_rd;
      logic     edge_take;
      logic     resp_load;
      kind_type resp_kind;
      logic     flush;
   } cmd_type;

   typedef struct packed {
      logic edge_reject;
      logic root_done;
      logic root_seen;
      logic pending_valid;
      logic out_free;
      logic depth_zero;
      logic cursor_null;
      logic target_new;
   } sts_type;

endpackage
`default_nettype wire

### sv/dfgt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// dfgt_ctrl
// Sequencer for edge inserts, graph clear and the stack-driven traversal.
// -----------------------------------------------------------------------------
module dfgt_ctrl
   import dfgt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [1:0] req_tuser,
   input  wire sts_type    sts,
   output cmd_type         cmd
);

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_ADD      = 11'b000_0000_0010,
      S_ADD_WR   = 11'b000_0000_0100,
      S_RESP     = 11'b000_0000_1000,
      S_ROOT     = 11'b000_0001_0000,
      S_ENTER    = 11'b000_0010_0000,
      S_PUSH     = 11'b000_0100_0000,
      S_STEP     = 11'b000_1000_0000,
      S_POP_WAIT = 11'b001_0000_0000,
      S_EDGE     = 11'b010_0000_0000,
      S_FLUSH    = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   kind_type  resp_kind_ff, resp_kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      resp_kind_ff <= resp_kind_in;
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      resp_kind_in  = resp_kind_ff;
      cmd           = '0;
      cmd.resp_kind = resp_kind_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.take_item = 1'b1;
               unique case (req_tuser)
                  ACT_ADD: begin
                     state_in = S_ADD;
                  end
                  ACT_RUN: begin
                     cmd.run_init = 1'b1;
                     state_in     = S_ROOT;
                  end
                  ACT_CLEAR: begin
                     cmd.clear_graph = 1'b1;
                     resp_kind_in    = KIND_CLEARED;
                     state_in        = S_RESP;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_ADD: begin
            if (sts.edge_reject) begin
               resp_kind_in = KIND_REJECT;
               state_in     = S_RESP;
            end else begin
               cmd.head_rd_from = 1'b1;
               state_in         = S_ADD_WR;
            end
         end
         S_ADD_WR: begin
            cmd.add_edge = 1'b1;
            resp_kind_in = KIND_STORED;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (sts.out_free) begin
               cmd.resp_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_ROOT: begin
            priority if (sts.root_done) begin
               state_in = S_FLUSH;
            end else if (sts.root_seen) begin
               cmd.root_next = 1'b1;
            end else begin
               cmd.cand_root = 1'b1;
               state_in      = S_ENTER;
            end
         end
         S_ENTER: begin
            if (!sts.pending_valid || sts.out_free) begin
               cmd.enter = 1'b1;
               state_in  = S_PUSH;
            end
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            state_in = S_STEP;
         end
         S_STEP: begin
            priority if (sts.depth_zero) begin
               cmd.root_next = 1'b1;
               state_in      = S_ROOT;
            end else if (sts.cursor_null) begin
               cmd.pop  = 1'b1;
               state_in = S_POP_WAIT;
            end else begin
               cmd.edge_rd = 1'b1;
               state_in    = S_EDGE;
            end
         end
         S_POP_WAIT: begin
            cmd.pop_load = 1'b1;
            state_in     = S_STEP;
         end
         S_EDGE: begin
            cmd.edge_take = 1'b1;
            if (sts.target_new) begin
               cmd.cand_target = 1'b1;
               state_in        = S_ENTER;
            end else begin
               state_in = S_STEP;
            end
         end
         S_FLUSH: begin
            if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_take_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.take_item |-> state_ff == S_IDLE)
      else $error("item taken while busy");

   a_push_after_enter: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> $past(cmd.enter))
      else $error("push without a preceding enter");

   a_edge_take_after_rd: assert property (@(posedge clock) disable iff (reset)
      cmd.edge_take |-> $past(cmd.edge_rd))
      else $error("edge data used without a read");

endmodule
`default_nettype wire

### sv/dfgt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// dfgt_datapath
// Edge store, list heads, visit marks, frame stack and result register.
// -----------------------------------------------------------------------------
module dfgt_datapath
   import dfgt_pkg::*;
#(
   parameter int MAX_VERTICES = 32,
   parameter int MAX_EDGES    = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   input  wire logic [CFG_DATA_W-1:0]  csr_data,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   input  wire cmd_type                cmd,
   output sts_type                     sts,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   output logic [1:0]                  rsp_tuser,
   output logic                        rsp_tlast
);

   localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int AW = $clog2(MAX_EDGES);
   localparam int EW = AW + 1;
   localparam logic [EW-1:0]       EDGE_NULL = EW'(MAX_EDGES);
   localparam logic [ACTIVE_W-1:0] NV_MAX    = ACTIVE_W'(MAX_VERTICES);
   localparam int FW = VW + EW;

   logic [CFG_W-1:0]      vc_ff;
   logic [ACTIVE_W-1:0]   n_act;
   logic [VERTEX_W-1:0]   from_ff, to_ff;
   logic [EW-1:0]         count_ff;
   logic [MAX_VERTICES-1:0] head_valid_ff, visited_ff;
   logic [EW-1:0]         head_mem [MAX_VERTICES];
   logic [EW-1:0]         head_rd_ff;
   logic                  head_vld_rd_ff;
   logic [EW-1:0]         head_q;
   logic [VW-1:0]         head_addr;
   logic [VERTEX_W-1:0]   edge_tgt_mem [MAX_EDGES];
   logic [EW-1:0]         edge_nxt_mem [MAX_EDGES];
   logic [VERTEX_W-1:0]   ed_tgt_ff;
   logic [EW-1:0]         ed_nxt_ff;
   logic [FW-1:0]         stack_mem [MAX_VERTICES];
   logic [FW-1:0]         stack_q_ff;
   logic [CW-1:0]         depth_ff, root_ff;
   logic [VW-1:0]         cand_ff, top_v_ff, pending_v_ff;
   logic [EW-1:0]         top_c_ff;
   logic                  pending_valid_ff;
   logic                  rsp_valid_ff, rsp_last_ff;
   kind_type              rsp_kind_ff;
   logic [VERTEX_W-1:0]   rsp_vertex_ff;
   logic                  out_load;

   always_comb begin
      priority if (vc_ff == '0) begin
         n_act = ACTIVE_W'(1);
      end else if ({1'b0, vc_ff} > NV_MAX) begin
         n_act = NV_MAX;
      end else begin
         n_act = {1'b0, vc_ff};
      end
   end

   assign head_q    = head_vld_rd_ff ? head_rd_ff : EDGE_NULL;
   assign head_addr = cmd.enter ? cand_ff : VW'(from_ff);

   assign sts.edge_reject   = ({2'b0, from_ff} >= n_act) || ({2'b0, to_ff} >= n_act)
                              || (count_ff >= EDGE_NULL);
   assign sts.root_done     = ACTIVE_W'(root_ff) >= n_act;
   assign sts.root_seen     = visited_ff[VW'(root_ff)];
   assign sts.pending_valid = pending_valid_ff;
   assign sts.out_free      = !rsp_valid_ff || rsp_tready;
   assign sts.depth_zero    = (depth_ff == '0);
   assign sts.cursor_null   = (top_c_ff >= EDGE_NULL);
   assign sts.target_new    = ({2'b0, ed_tgt_ff} < n_act) && !visited_ff[VW'(ed_tgt_ff)];

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff            <= VCOUNT_RESET;
         count_ff         <= '0;
         head_valid_ff    <= '0;
         visited_ff       <= '0;
         depth_ff         <= '0;
         root_ff          <= '0;
         pending_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            vc_ff <= csr_data[CFG_W-1:0];
         end
         if (cmd.clear_graph) begin
            count_ff      <= '0;
            head_valid_ff <= '0;
         end
         if (cmd.add_edge) begin
            count_ff                     <= count_ff + EW'(1);
            head_valid_ff[VW'(from_ff)]  <= 1'b1;
         end
         if (cmd.run_init) begin
            visited_ff       <= '0;
            depth_ff         <= '0;
            root_ff          <= '0;
            pending_valid_ff <= 1'b0;
         end
         if (cmd.root_next) begin
            root_ff <= root_ff + CW'(1);
         end
         if (cmd.enter) begin
            visited_ff[cand_ff] <= 1'b1;
            pending_valid_ff    <= 1'b1;
         end
         if (cmd.flush) begin
            pending_valid_ff <= 1'b0;
         end
         if (cmd.push) begin
            depth_ff <= depth_ff + CW'(1);
         end
         if (cmd.pop) begin
            depth_ff <= depth_ff - CW'(1);
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         from_ff <= req_tdata[VERTEX_W-1:0];
         to_ff   <= req_tdata[2*VERTEX_W-1:VERTEX_W];
      end
      if (cmd.cand_root) begin
         cand_ff <= VW'(root_ff);
      end
      if (cmd.cand_target) begin
         cand_ff <= VW'(ed_tgt_ff);
      end
      if (cmd.enter) begin
         pending_v_ff <= cand_ff;
      end
      if (cmd.push) begin
         top_v_ff <= cand_ff;
         top_c_ff <= head_q;
      end
      if (cmd.pop_load) begin
         top_v_ff <= stack_q_ff[FW-1:EW];
         top_c_ff <= stack_q_ff[EW-1:0];
      end
      if (cmd.edge_take) begin
         top_c_ff <= ed_nxt_ff;
      end
   end

   // list heads
   always_ff @(posedge clock) begin
      if (cmd.add_edge) begin
         head_mem[VW'(from_ff)] <= count_ff;
      end
      if (cmd.head_rd_from || cmd.enter) begin
         head_rd_ff     <= head_mem[head_addr];
         head_vld_rd_ff <= head_valid_ff[head_addr];
      end
   end

   // edge store
   always_ff @(posedge clock) begin
      if (cmd.add_edge) begin
         edge_tgt_mem[AW'(count_ff)] <= to_ff;
         edge_nxt_mem[AW'(count_ff)] <= head_q;
      end
      if (cmd.edge_rd) begin
         ed_tgt_ff <= edge_tgt_mem[AW'(top_c_ff)];
         ed_nxt_ff <= edge_nxt_mem[AW'(top_c_ff)];
      end
   end

   // frames below the top of stack
   always_ff @(posedge clock) begin
      if (cmd.push && (depth_ff != '0)) begin
         stack_mem[VW'(depth_ff - CW'(1))] <= {top_v_ff, top_c_ff};
      end
      if (cmd.pop) begin
         stack_q_ff <= stack_mem[VW'(depth_ff - CW'(2))];
      end
   end

   // result register
   assign out_load = cmd.resp_load || cmd.flush || (cmd.enter && pending_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resp_load) begin
         rsp_kind_ff   <= cmd.resp_kind;
         rsp_vertex_ff <= '0;
         rsp_last_ff   <= 1'b1;
      end else if (out_load) begin
         rsp_kind_ff   <= KIND_VISIT;
         rsp_vertex_ff <= VERTEX_W'(pending_v_ff);
         rsp_last_ff   <= cmd.flush;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_vertex_ff);
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> depth_ff < CW'(MAX_VERTICES))
      else $error("frame stack overflow");

   a_store_legal: assert property (@(posedge clock) disable iff (reset)
      cmd.add_edge |-> !sts.edge_reject)
      else $error("edge stored although rejected");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= EDGE_NULL)
      else $error("edge count beyond store");

endmodule
`default_nettype wire

### sv/depth_first_graph_traversal.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// depth_first_graph_traversal
// Directed graph store with depth-first preorder traversal.
// -----------------------------------------------------------------------------
// One item is taken at a time. An add-edge item steps through a check with
// list-head read, a store and a result load before its result is offered; a
// rejected one goes from the check straight to the result load, and a clear
// item to the result load. A run item checks each root vertex in turn, then
// in each walk enters vertices (enter with list-head read, push), follows
// edges (cursor test and edge-store read) and finishes vertices (pop and
// frame read), and flushes the final result once it finds the roots
// exhausted; the single-port edge store and frame stack each have a
// registered read. Results are marked tlast on the final one of each item;
// a stalled result register holds the walk. No clearing pass is needed
// after reset.
module depth_first_graph_traversal
   import dfgt_pkg::*;
#(
   parameter int MAX_VERTICES = 32,
   parameter int MAX_EDGES    = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CFG_DATA_W-1:0]  csr_data,     // [5:0] vertex_count
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,    // [4:0] from_vertex, [9:5] to_vertex
   input  wire logic [1:0]             req_tuser,    // [1:0] action
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,    // [4:0] visited_vertex
   output logic [1:0]                  rsp_tuser,    // [1:0] result_kind
   output logic                        rsp_tlast
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   dfgt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   dfgt_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire
